// ===== src/weno5_pkg.sv =====
// ---------------------------------------------------------------------------
// weno5_pkg
// Shared widths, codes, types and the linear weight table for the WENO5
// face state reconstruction block.
// ---------------------------------------------------------------------------
package weno5_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int FRAC_BITS   = 24;
  localparam int RATIO_BITS  = 30;
  localparam int WEIGHT_BITS = 24;
  localparam int WIN_DEPTH   = 6;
  localparam int STENCIL     = 5;
  localparam int FILL_W      = 3;
  localparam int Q_DEPTH     = 2;

  // internal arithmetic widths
  localparam int DIFF_W  = 35;
  localparam int NUM_W   = 37;
  localparam int SQ_W    = 46;
  localparam int BETA_W  = 47;
  localparam int B_W     = 48;
  localparam int DEN_W   = 49;
  localparam int REM_W   = 50;
  localparam int DIV_W   = 50;
  localparam int STEP_W  = 6;
  localparam int RATIO_W = 31;
  localparam int TERM_W  = 32;
  localparam int A_W     = 34;
  localparam int SUM_W   = 35;
  localparam int W_W     = 25;
  localparam int ACC_W   = 62;

  // divide by three, 16-bit digits through a reciprocal multiply
  localparam int DIV3_W       = 48;
  localparam int DIV3_DIGIT_W = 16;
  localparam int DIV3_V_W     = 18;
  localparam int DIV3_SHIFT   = 19;
  localparam logic [DIV3_V_W-1:0] DIV3_RECIP  = 18'd174763;
  localparam logic [1:0]          DIV3_DIGITS = 2'd3;

  // configuration port
  localparam int EPS_W       = 25;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_MODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON     = 8'd1;
  localparam logic [EPS_W-1:0]       EPS_RESET       = 25'd17;
  localparam logic WMODE_JS = 1'b0;
  localparam logic WMODE_Z  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WIN_DEPTH-1:0] window_t;

  typedef struct packed {
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  // linear weights 1/10, 6/10, 3/10 as integer numerators
  function automatic logic [2:0] lin_weight(input logic [1:0] k);
    logic [2:0] g;
    case (k)
      2'd0:    g = 3'd1;
      2'd1:    g = 3'd6;
      2'd2:    g = 3'd3;
      default: g = 3'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== src/weno5_if.sv =====
// ---------------------------------------------------------------------------
// weno5 channel interfaces
// Cell input stream, face result stream and configuration write channel.
// ---------------------------------------------------------------------------
interface weno5_cell_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [weno5_pkg::SAMPLE_W-1:0] cell_value;
  logic                                  line_start;
  modport source (output valid, cell_value, line_start, input ready);
  modport sink   (input valid, cell_value, line_start, output ready);
endinterface

interface weno5_face_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [weno5_pkg::SAMPLE_W-1:0] left_state;
  logic signed [weno5_pkg::SAMPLE_W-1:0] right_state;
  modport source (output valid, left_state, right_state, input ready);
  modport sink   (input valid, left_state, right_state, output ready);
endinterface

interface weno5_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [weno5_pkg::CFG_INDEX_W-1:0]   index;
  logic [weno5_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/weno5_face_state_reconstruct.sv =====
// ---------------------------------------------------------------------------
// weno5_face_state_reconstruct
// Streaming fifth-order WENO reconstruction of left and right face states.
// ---------------------------------------------------------------------------
// Cells of one grid line enter on the cells channel, one per item; line_start
// restarts the window fill. From the sixth cell of a line on, every cell gives one
// item on the faces channel: the left and right states of the face between
// the window's third and fourth cells, Q8.24, rounded and saturated.
// The cfg channel writes weight_mode (index 0: 0 Jiang-Shu, 1 WENO-Z) and
// epsilon (index 1); it is always ready, other indexes are ignored.
// Cells are taken whenever the queue is not full. A window that produces a
// result is queued (two entries) and evaluated by a sequencer around one
// shared bit-serial fraction divider, which gives one quotient bit per
// cycle. Results leave through an output register, so
// a stalled receiver holds the result while the next window is evaluated and
// the queue keeps taking cells until it is full.
// Reset empties the window, queue and output, sets weight_mode to 0 and
// epsilon to 17.
// ---------------------------------------------------------------------------
module weno5_face_state_reconstruct (
  input  logic         clk,
  input  logic         rst,
  weno5_cell_if.sink   cells,
  weno5_face_if.source faces,
  weno5_cfg_if.sink    cfg
);
  import weno5_pkg::*;

  logic             weight_mode;
  logic [EPS_W-1:0] epsilon;
  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  window_t          q_wdata;
  window_t          q_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= WMODE_JS;
      epsilon     <= EPS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_WEIGHT_MODE: weight_mode <= cfg.data[0];
        CFG_EPSILON:     epsilon     <= cfg.data[EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  weno5_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  weno5_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  weno5_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  weno5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .weight_mode (weight_mode),
    .epsilon     (epsilon),
    .q_stat      (q_stat),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .faces       (faces)
  );

endmodule

// ===== src/weno5_front.sv =====
// ---------------------------------------------------------------------------
// weno5_front
// Accepts cells, keeps the six-cell window and fill count, and queues a
// window snapshot for every cell that leaves the six-cell window full.
// ---------------------------------------------------------------------------
module weno5_front (
  input  logic                clk,
  input  logic                rst,
  weno5_cell_if.sink          cells,
  input  weno5_pkg::q_stat_t  q_stat,
  output logic                q_push,
  output weno5_pkg::window_t  q_wdata
);
  import weno5_pkg::*;

  window_t           win;
  window_t           win_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              accept;

  assign cells.ready = !q_stat.full;
  assign accept      = cells.valid && cells.ready;

  always_comb begin
    // oldest cell at index 0, newest enters at the top
    win_next = {cells.cell_value, win[WIN_DEPTH-1:1]};
    if (cells.line_start) begin
      fill_next = FILL_W'(1);
    end else if (fill < FILL_W'(WIN_DEPTH)) begin
      fill_next = fill + FILL_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  assign q_push  = accept && (fill_next == FILL_W'(WIN_DEPTH));
  assign q_wdata = win_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= '0;
      fill <= '0;
    end else if (accept) begin
      win  <= win_next;
      fill <= fill_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FILL_W'(WIN_DEPTH))
    else $error("fill count beyond window depth");

endmodule

// ===== src/weno5_queue.sv =====
// ---------------------------------------------------------------------------
// weno5_queue
// Two-entry queue of window snapshots between the front and back parts.
// ---------------------------------------------------------------------------
module weno5_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  weno5_pkg::window_t  wdata,
  input  logic                pop,
  output weno5_pkg::window_t  rdata,
  output weno5_pkg::q_stat_t  stat
);
  import weno5_pkg::*;

  window_t    slot [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata      = slot[rd_ptr];
  assign stat.full  = (count == 2'(Q_DEPTH));
  assign stat.empty = (count == 2'd0);

  assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("push into full queue");

endmodule

// ===== src/weno5_div.sv =====
// ---------------------------------------------------------------------------
// weno5_div
// Shared bit-serial restoring divider for fractions, one quotient bit per
// cycle: the remainder starts at the numerator and zeros are shifted in.
// ---------------------------------------------------------------------------
module weno5_div (
  input  logic                clk,
  input  logic                rst,
  input  weno5_pkg::div_req_t req,
  output weno5_pkg::div_rsp_t rsp
);
  import weno5_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DEN_W-1:0]  den;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    trial = {rem[REM_W-2:0], 1'b0};
    fits  = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, den}) : trial;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ===== src/weno5_back.sv =====
// ---------------------------------------------------------------------------
// weno5_back
// Sequencer that evaluates the WENO5 formula on a queued window, first on
// the left stencil and then on the mirrored one, and holds the result pair
// in an output register.
// ---------------------------------------------------------------------------
module weno5_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        weight_mode,
  input  logic [weno5_pkg::EPS_W-1:0] epsilon,
  input  weno5_pkg::q_stat_t          q_stat,
  input  weno5_pkg::window_t          q_rdata,
  output logic                        q_pop,
  output weno5_pkg::div_req_t         div_req,
  input  weno5_pkg::div_rsp_t         div_rsp,
  weno5_face_if.source                faces
);
  import weno5_pkg::*;

  typedef enum logic [23:0] {
    ST_IDLE  = 24'h000001,
    ST_DIFF  = 24'h000002,
    ST_SQA   = 24'h000004,
    ST_SQB   = 24'h000008,
    ST_BETA  = 24'h000010,
    ST_BWAIT = 24'h000020,
    ST_MIN   = 24'h000040,
    ST_RATIO = 24'h000080,
    ST_RWAIT = 24'h000100,
    ST_EF    = 24'h000200,
    ST_EWAIT = 24'h000400,
    ST_UF    = 24'h000800,
    ST_UWAIT = 24'h001000,
    ST_EE    = 24'h002000,
    ST_TT    = 24'h004000,
    ST_HH    = 24'h008000,
    ST_GA    = 24'h010000,
    ST_SUM   = 24'h020000,
    ST_WGT   = 24'h040000,
    ST_WWAIT = 24'h080000,
    ST_ACC   = 24'h100000,
    ST_FIN   = 24'h200000,
    ST_FWAIT = 24'h400000,
    ST_OUT   = 24'h800000
  } state_t;

  localparam logic [1:0] LAST_K = 2'd2;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_BITS;
  localparam logic [W_W-1:0]     WEIGHT_ONE = W_W'(1) << WEIGHT_BITS;

  state_t state;
  logic [1:0] k;
  logic       face;
  window_t    win;

  logic signed [DIFF_W-1:0] da [3];
  logic signed [DIFF_W-1:0] db [3];
  logic signed [NUM_W-1:0]  num [3];
  logic [SQ_W-1:0]    sqa;
  logic [SQ_W-1:0]    sqb;
  logic [BETA_W-1:0]  beta [3];
  logic [B_W-1:0]     b [3];
  logic [B_W-1:0]     m;
  logic [BETA_W-1:0]  tau;
  logic [RATIO_W-1:0] rr [3];
  logic [RATIO_W-1:0] ef;
  logic [RATIO_W-1:0] uf;
  logic [RATIO_W-1:0] ee;
  logic [RATIO_W-1:0] tk [3];
  logic [TERM_W-1:0]  hh [3];
  logic [A_W-1:0]     a [3];
  logic [SUM_W-1:0]   sum;
  logic [W_W-1:0]     w [3];
  logic signed [ACC_W-1:0] acc;
  sample_t left_res;
  sample_t right_res;
  logic    out_valid;
  sample_t out_left;
  sample_t out_right;

  // divide-by-three unit, one 16-bit quotient digit per cycle
  logic [DIV3_W-1:0] d3_dvd;
  logic [DIV3_W-1:0] d3_quo;
  logic [1:0]        d3_rem;
  logic [1:0]        d3_cnt;

  // combinational helpers
  logic signed [NUM_W-1:0]  e [STENCIL];
  logic signed [DIFF_W-1:0] dsel;
  logic [DIFF_W-1:0]        dmag;
  logic [2*DIFF_W-1:0]      sq_full;
  logic [DIV_W-1:0]         beta_num;
  logic [EPS_W-1:0]         eps_eff;
  logic [B_W-1:0]           bc [3];
  logic [B_W-1:0]           mc;
  logic [DEN_W-1:0]         den_z;
  logic [RATIO_W-1:0]       mul_a;
  logic [RATIO_W-1:0]       mul_b;
  logic [2*RATIO_W-1:0]     mul_p;
  logic [TERM_W-1:0]        mul_hi;
  logic signed [W_W+NUM_W:0] wprod;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W:0]           acc_rnd;
  logic [DIV3_W-1:0]        lim_neg;
  sample_t                  sat_res;
  logic                     slot_free;
  state_t                   after_ratio;
  logic [DIV3_V_W-1:0]      d3_v;
  logic [2*DIV3_V_W-1:0]    d3_p;
  logic [DIV3_DIGIT_W-1:0]  d3_qd;
  logic [DIV3_V_W-1:0]      d3_r;
  logic                     d3_done;

  always_comb begin
    for (int i = 0; i < STENCIL; i++) begin
      e[i] = face ? NUM_W'(win[WIN_DEPTH-1-i]) : NUM_W'(win[i]);
    end

    dsel    = (state == ST_SQA) ? da[k] : db[k];
    dmag    = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
    sq_full = dmag * dmag;

    beta_num = DIV_W'(sqa) * DIV_W'(13) + DIV_W'(sqb) * DIV_W'(3);

    eps_eff = (epsilon == '0) ? EPS_W'(1) : epsilon;
    for (int i = 0; i < 3; i++) begin
      bc[i] = B_W'(beta[i]) + B_W'(eps_eff);
    end
    mc = bc[0];
    if (bc[1] < mc) begin
      mc = bc[1];
    end
    if (bc[2] < mc) begin
      mc = bc[2];
    end
    den_z = DEN_W'(m) + DEN_W'(tau);

    // one shared multiplier for the ratio squares and products
    case (state)
      ST_EE: begin
        mul_a = ef;
        mul_b = ef;
      end
      ST_TT: begin
        mul_a = uf;
        mul_b = rr[k];
      end
      ST_HH: begin
        mul_a = (weight_mode == WMODE_Z) ? tk[k] : rr[k];
        mul_b = (weight_mode == WMODE_Z) ? tk[k] : rr[k];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p  = mul_a * mul_b;
    mul_hi = mul_p[2*RATIO_W-1:RATIO_BITS];

    wprod = $signed({1'b0, w[k]}) * num[k];

    acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    acc_rnd = {1'b0, acc_mag} + ((ACC_W+1)'(3) << WEIGHT_BITS);

    // remainder below three, so the reciprocal estimate is exact per digit
    d3_v    = {d3_rem, d3_dvd[DIV3_W-1 -: DIV3_DIGIT_W]};
    d3_p    = d3_v * DIV3_RECIP;
    d3_qd   = d3_p[DIV3_SHIFT +: DIV3_DIGIT_W];
    d3_r    = d3_v - DIV3_V_W'(d3_qd) * DIV3_V_W'(3);
    d3_done = (d3_cnt == 2'd0);

    lim_neg = DIV3_W'(1) << (SAMPLE_W-1);
    if (acc[ACC_W-1]) begin
      sat_res = (d3_quo > lim_neg) ? SAMPLE_W'(lim_neg)
                                   : SAMPLE_W'(DIV3_W'(0) - d3_quo);
    end else begin
      sat_res = (d3_quo > lim_neg - DIV3_W'(1)) ? SAMPLE_W'(lim_neg - DIV3_W'(1))
                                                : SAMPLE_W'(d3_quo);
    end

    slot_free   = !out_valid || faces.ready;
    after_ratio = (weight_mode == WMODE_Z) ? ST_EF : ST_HH;
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (state)
      ST_RATIO: begin
        div_req.start = (m < b[k]);
        div_req.rem   = REM_W'(m);
        div_req.den   = DEN_W'(b[k]);
        div_req.steps = STEP_W'(RATIO_BITS);
      end
      ST_EF: begin
        div_req.start = (DEN_W'(m) < den_z);
        div_req.rem   = REM_W'(m);
        div_req.den   = den_z;
        div_req.steps = STEP_W'(RATIO_BITS);
      end
      ST_UF: begin
        div_req.start = (DEN_W'(tau) < den_z);
        div_req.rem   = REM_W'(tau);
        div_req.den   = den_z;
        div_req.steps = STEP_W'(RATIO_BITS);
      end
      ST_WGT: begin
        div_req.start = (SUM_W'(a[k]) < sum);
        div_req.rem   = REM_W'(a[k]);
        div_req.den   = DEN_W'(sum);
        div_req.steps = STEP_W'(WEIGHT_BITS);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  assign q_pop = (state == ST_IDLE) && !q_stat.empty;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      face      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (faces.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            face  <= 1'b0;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          k     <= '0;
          state <= ST_SQA;
        end
        ST_SQA:   state <= ST_SQB;
        ST_SQB:   state <= ST_BETA;
        ST_BETA:  state <= ST_BWAIT;
        ST_BWAIT: begin
          if (d3_done) begin
            if (k == LAST_K) begin
              k     <= '0;
              state <= ST_MIN;
            end else begin
              k     <= k + 2'd1;
              state <= ST_SQA;
            end
          end
        end
        ST_MIN: state <= ST_RATIO;
        ST_RATIO: begin
          if (m < b[k]) begin
            state <= ST_RWAIT;
          end else if (k == LAST_K) begin
            k     <= '0;
            state <= after_ratio;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_RWAIT: begin
          if (div_rsp.done) begin
            if (k == LAST_K) begin
              k     <= '0;
              state <= after_ratio;
            end else begin
              k     <= k + 2'd1;
              state <= ST_RATIO;
            end
          end
        end
        ST_EF: state <= (DEN_W'(m) < den_z) ? ST_EWAIT : ST_UF;
        ST_EWAIT: begin
          if (div_rsp.done) begin
            state <= ST_UF;
          end
        end
        ST_UF: state <= (DEN_W'(tau) < den_z) ? ST_UWAIT : ST_EE;
        ST_UWAIT: begin
          if (div_rsp.done) begin
            state <= ST_EE;
          end
        end
        ST_EE: begin
          k     <= '0;
          state <= ST_TT;
        end
        ST_TT: begin
          if (k == LAST_K) begin
            k     <= '0;
            state <= ST_HH;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_HH: begin
          if (k == LAST_K) begin
            k     <= '0;
            state <= ST_GA;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_GA:  state <= ST_SUM;
        ST_SUM: begin
          k     <= '0;
          state <= ST_WGT;
        end
        ST_WGT: begin
          if (SUM_W'(a[k]) < sum) begin
            state <= ST_WWAIT;
          end else if (k == LAST_K) begin
            k     <= '0;
            state <= ST_ACC;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_WWAIT: begin
          if (div_rsp.done) begin
            if (k == LAST_K) begin
              k     <= '0;
              state <= ST_ACC;
            end else begin
              k     <= k + 2'd1;
              state <= ST_WGT;
            end
          end
        end
        ST_ACC: begin
          if (k == LAST_K) begin
            k     <= '0;
            state <= ST_FIN;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_FIN: state <= ST_FWAIT;
        ST_FWAIT: begin
          if (d3_done) begin
            if (face == 1'b0) begin
              face  <= 1'b1;
              state <= ST_DIFF;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          win <= q_rdata;
        end
      end
      ST_DIFF: begin
        da[0]  <= DIFF_W'(e[0] - e[1] * 2 + e[2]);
        db[0]  <= DIFF_W'(e[0] - e[1] * 4 + e[2] * 3);
        da[1]  <= DIFF_W'(e[1] - e[2] * 2 + e[3]);
        db[1]  <= DIFF_W'(e[1] - e[3]);
        da[2]  <= DIFF_W'(e[2] - e[3] * 2 + e[4]);
        db[2]  <= DIFF_W'(e[2] * 3 - e[3] * 4 + e[4]);
        num[0] <= e[0] * 2 - e[1] * 7 + e[2] * 11;
        num[1] <= e[2] * 5 - e[1] + e[3] * 2;
        num[2] <= e[2] * 2 + e[3] * 5 - e[4];
      end
      ST_SQA: sqa <= sq_full[2*DIFF_W-1:FRAC_BITS];
      ST_SQB: sqb <= sq_full[2*DIFF_W-1:FRAC_BITS];
      // divide by 12 as a shift by two and a divide by three
      ST_BETA: begin
        d3_dvd <= DIV3_W'(beta_num >> 2);
        d3_rem <= 2'd0;
        d3_cnt <= DIV3_DIGITS;
      end
      ST_BWAIT: begin
        if (d3_done) begin
          beta[k] <= BETA_W'(d3_quo);
        end else begin
          d3_dvd <= d3_dvd << DIV3_DIGIT_W;
          d3_quo <= {d3_quo[DIV3_W-DIV3_DIGIT_W-1:0], d3_qd};
          d3_rem <= d3_r[1:0];
          d3_cnt <= d3_cnt - 2'd1;
        end
      end
      ST_MIN: begin
        for (int i = 0; i < 3; i++) begin
          b[i] <= bc[i];
        end
        m   <= mc;
        tau <= (beta[0] > beta[2]) ? (beta[0] - beta[2]) : (beta[2] - beta[0]);
      end
      ST_RATIO: begin
        if (m >= b[k]) begin
          rr[k] <= RATIO_ONE;
        end
      end
      ST_RWAIT: begin
        if (div_rsp.done) begin
          rr[k] <= RATIO_W'(div_rsp.quo);
        end
      end
      ST_EF: begin
        if (DEN_W'(m) >= den_z) begin
          ef <= RATIO_ONE;
        end
      end
      ST_EWAIT: begin
        if (div_rsp.done) begin
          ef <= RATIO_W'(div_rsp.quo);
        end
      end
      ST_UF: begin
        if (DEN_W'(tau) >= den_z) begin
          uf <= RATIO_ONE;
        end
      end
      ST_UWAIT: begin
        if (div_rsp.done) begin
          uf <= RATIO_W'(div_rsp.quo);
        end
      end
      ST_EE: ee    <= RATIO_W'(mul_hi);
      ST_TT: tk[k] <= RATIO_W'(mul_hi);
      ST_HH: begin
        hh[k] <= (weight_mode == WMODE_Z) ? (TERM_W'(ee) + mul_hi) : mul_hi;
      end
      ST_GA: begin
        for (int i = 0; i < 3; i++) begin
          a[i] <= A_W'(hh[i]) * A_W'(lin_weight(2'(i)));
        end
      end
      ST_SUM: begin
        sum <= SUM_W'(a[0]) + SUM_W'(a[1]) + SUM_W'(a[2]);
        acc <= '0;
      end
      ST_WGT: begin
        if (SUM_W'(a[k]) >= sum) begin
          w[k] <= WEIGHT_ONE;
        end
      end
      ST_WWAIT: begin
        if (div_rsp.done) begin
          w[k] <= W_W'(div_rsp.quo);
        end
      end
      ST_ACC: acc <= acc + ACC_W'(wprod);
      // divide by 6 * 2^24 as a shift by 25 and a divide by three
      ST_FIN: begin
        d3_dvd <= DIV3_W'(acc_rnd >> (WEIGHT_BITS + 1));
        d3_rem <= 2'd0;
        d3_cnt <= DIV3_DIGITS;
      end
      ST_FWAIT: begin
        if (d3_done) begin
          if (face == 1'b0) begin
            left_res <= sat_res;
          end else begin
            right_res <= sat_res;
          end
        end else begin
          d3_dvd <= d3_dvd << DIV3_DIGIT_W;
          d3_quo <= {d3_quo[DIV3_W-DIV3_DIGIT_W-1:0], d3_qd};
          d3_rem <= d3_r[1:0];
          d3_cnt <= d3_cnt - 2'd1;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_left  <= left_res;
          out_right <= right_res;
        end
      end
      default: begin
      end
    endcase
  end

  assign faces.valid       = out_valid;
  assign faces.left_state  = out_left;
  assign faces.right_state = out_right;

  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_RWAIT || state == ST_EWAIT ||
                      state == ST_UWAIT || state == ST_WWAIT))
    else $error("divider finished outside a wait state");

  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

endmodule

// ===== sim/tb_weno5_face_state_reconstruct.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_weno5_face_state_reconstruct
// Streams grid lines of cells through the WENO5 block under several weight
// modes and epsilon settings, predicts every face state pair in the bench and
// compares each result field by field, with random sender gaps and receiver
// stalls, including one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_weno5_face_state_reconstruct;
  import weno5_pkg::*;

  typedef struct {
    sample_t value;
    logic    start;
  } cell_item_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } face_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  weno5_cell_if cells_ch ();
  weno5_face_if faces_ch ();
  weno5_cfg_if  cfg_ch ();

  weno5_face_state_reconstruct dut (
    .clk   (clk),
    .rst   (rst),
    .cells (cells_ch.sink),
    .faces (faces_ch.source),
    .cfg   (cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cell_item_t cell_q[$];
  face_pair_t face_q[$];

  // bench copy of the block's state and registers
  longint      win[WIN_DEPTH] = '{default: 0};
  int          fill_n = 0;
  logic        wmode;
  longint      eps_reg;

  int          err_n = 0;
  int          cells_n = 0;
  int          faces_n = 0;
  int          settings_n;
  longint      cycle_n = 0;
  logic        hold_req;

  // ---- predictor ----------------------------------------------------------
  function automatic longint unsigned frac_q(longint unsigned num, longint unsigned den,
                                             int bits);
    logic [127:0] wide;
    if (den == 0) return 0;
    if (num >= den) return 64'd1 << bits;
    wide = {64'd0, num} << bits;
    wide = wide / den;
    return wide[63:0];
  endfunction

  function automatic longint unsigned sq_q(longint d);
    longint unsigned mag;
    logic [127:0]    wide;
    mag  = d < 0 ? -d : d;
    wide = {64'd0, mag} * {64'd0, mag};
    wide = wide >> FRAC_BITS;
    return wide[63:0];
  endfunction

  function automatic longint unsigned smooth_ind(longint d, longint e);
    return (13 * sq_q(d) + 3 * sq_q(e)) / 12;
  endfunction

  function automatic sample_t face_value(longint s0, longint s1, longint s2,
                                         longint s3, longint s4);
    longint unsigned beta[3], b[3], r[3], a[3], w[3];
    longint unsigned g[3];
    longint          num[3];
    longint unsigned eps, m, total, mag, q, tau, ef, uf, ee, t;
    longint          acc;
    g[0] = 1; g[1] = 6; g[2] = 3;
    eps = eps_reg == 0 ? 1 : eps_reg;
    beta[0] = smooth_ind(s0 - 2 * s1 + s2, s0 - 4 * s1 + 3 * s2);
    beta[1] = smooth_ind(s1 - 2 * s2 + s3, s1 - s3);
    beta[2] = smooth_ind(s2 - 2 * s3 + s4, 3 * s2 - 4 * s3 + s4);
    num[0] = 2 * s0 - 7 * s1 + 11 * s2;
    num[1] = -s1 + 5 * s2 + 2 * s3;
    num[2] = 2 * s2 + 5 * s3 - s4;
    for (int k = 0; k < 3; k++) b[k] = beta[k] + eps;
    m = b[0];
    if (b[1] < m) m = b[1];
    if (b[2] < m) m = b[2];
    for (int k = 0; k < 3; k++) r[k] = frac_q(m, b[k], RATIO_BITS);
    if (wmode == WMODE_JS) begin
      for (int k = 0; k < 3; k++) a[k] = g[k] * ((r[k] * r[k]) >> RATIO_BITS);
    end else begin
      tau = beta[0] > beta[2] ? beta[0] - beta[2] : beta[2] - beta[0];
      ef  = frac_q(m, m + tau, RATIO_BITS);
      uf  = frac_q(tau, m + tau, RATIO_BITS);
      ee  = (ef * ef) >> RATIO_BITS;
      for (int k = 0; k < 3; k++) begin
        t    = (uf * r[k]) >> RATIO_BITS;
        a[k] = g[k] * (ee + ((t * t) >> RATIO_BITS));
      end
    end
    total = a[0] + a[1] + a[2];
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      w[k] = frac_q(a[k], total, WEIGHT_BITS);
      acc += longint'(w[k]) * num[k];
    end
    mag = acc < 0 ? -acc : acc;
    q = (mag + (64'd3 << WEIGHT_BITS)) / (64'd6 << WEIGHT_BITS);
    if (acc < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = -q;
    end else if (q > 64'h7fff_ffff) begin
      q = 64'h7fff_ffff;
    end
    return sample_t'(q[31:0]);
  endfunction

  // shift one accepted cell in and queue the face pair it yields, if any
  task automatic shift_cell(sample_t value, logic start);
    face_pair_t fp;
    for (int k = 0; k < WIN_DEPTH - 1; k++) win[k] = win[k + 1];
    win[WIN_DEPTH - 1] = longint'(value);
    if (start) fill_n = 1;
    else if (fill_n < WIN_DEPTH) fill_n++;
    if (fill_n == WIN_DEPTH) begin
      fp.left  = face_value(win[0], win[1], win[2], win[3], win[4]);
      fp.right = face_value(win[5], win[4], win[3], win[2], win[1]);
      face_q.push_back(fp);
    end
  endtask

  // ---- cell driver --------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    cell_item_t it;
    if (rst) begin
      cells_ch.valid      <= 1'b0;
      cells_ch.cell_value <= '0;
      cells_ch.line_start <= 1'b0;
      burst_left = 5;
      gap_left   = 0;
    end else begin
      if (cells_ch.valid && cells_ch.ready) begin
        shift_cell(cells_ch.cell_value, cells_ch.line_start);
        cells_n++;
      end
      if (!cells_ch.valid || cells_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cells_ch.valid <= 1'b0;
        end else if (cell_q.size() == 0) begin
          cells_ch.valid <= 1'b0;
        end else begin
          it = cell_q.pop_front();
          cells_ch.valid      <= 1'b1;
          cells_ch.cell_value <= it.value;
          cells_ch.line_start <= it.start;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // ---- face receiver ------------------------------------------------------
  int stall_mode;
  int mode_left;
  int hold_left;
  logic hold_done;

  always @(posedge clk) begin
    if (rst) begin
      faces_ch.ready <= 1'b0;
      stall_mode = 0;
      mode_left  = 300;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 6000;
      end
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(100, 3000);
      end
      if (hold_left > 0) begin
        hold_left--;
        faces_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       faces_ch.ready <= 1'b1;
          1:       faces_ch.ready <= $urandom_range(0, 1);
          default: faces_ch.ready <= (cycle_n % 7) >= 3;
        endcase
      end
    end
  end

  // ---- face checker -------------------------------------------------------
  always @(posedge clk) begin
    face_pair_t fp;
    if (!rst && faces_ch.valid && faces_ch.ready) begin
      if (face_q.size() == 0) begin
        if (err_n < 10) $display("unexpected face item: left %h right %h",
                                 faces_ch.left_state, faces_ch.right_state);
        err_n++;
      end else begin
        fp = face_q.pop_front();
        faces_n++;
        if (faces_ch.left_state !== fp.left) begin
          if (err_n < 10) $display("left_state mismatch: expected %h got %h",
                                   fp.left, faces_ch.left_state);
          err_n++;
        end
        if (faces_ch.right_state !== fp.right) begin
          if (err_n < 10) $display("right_state mismatch: expected %h got %h",
                                   fp.right, faces_ch.right_state);
          err_n++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > 64'd9_000_000) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---- stimulus -----------------------------------------------------------
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_WEIGHT_MODE) wmode = val[0];
    else if (idx == CFG_EPSILON) eps_reg = val[EPS_W-1:0];
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_cell(sample_t value, logic start);
    cell_item_t it;
    it.value = value;
    it.start = start;
    cell_q.push_back(it);
  endtask

  function automatic sample_t pick_cell(int style, int k, int jump_at, sample_t base,
                                        int slope);
    case (style)
      0:       return base + sample_t'(k * slope);
      1:       return sample_t'($urandom);
      2:       return k < jump_at ? base : base + sample_t'($urandom_range(0, 32'hffff_ffff));
      default: return ($urandom % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  // one line of random content; noisy lines are short and may carry stray starts
  task automatic push_line(logic noisy);
    int      len, style, jump_at, slope;
    sample_t base;
    len     = noisy ? $urandom_range(1, 5) : $urandom_range(6, 14);
    style   = $urandom_range(0, 3);
    jump_at = $urandom_range(1, len);
    base    = ($urandom % 2) ? sample_t'($urandom) : sample_t'($urandom_range(0, 32'h0400_0000))
              - 32'sh0200_0000;
    slope   = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    for (int k = 0; k < len; k++)
      push_cell(pick_cell(style, k, jump_at, base, slope),
                k == 0 || (noisy && $urandom % 4 == 0));
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (cell_q.size() != 0 || cells_ch.valid || face_q.size() != 0);
    repeat (1000) @(posedge clk);
  endtask

  logic [EPS_W-1:0] eps_set[6];
  logic             mode_set[6];

  initial begin
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    hold_req   = 1'b0;
    settings_n = 0;
    wmode      = WMODE_JS;
    eps_reg    = EPS_RESET;
    mode_set = '{WMODE_JS, WMODE_Z, WMODE_JS, WMODE_Z, WMODE_Z, WMODE_JS};
    eps_set  = '{25'd17, 25'd17, 25'd1, 25'd16777216, 25'd0, 25'h1ff_ffff};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WEIGHT_MODE, {$urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0, mode_set[ph]});
      // upper data bits are junk the block must drop
      write_reg(CFG_EPSILON, {7'($urandom_range(0, 127)), eps_set[ph]});
      if (ph == 0) write_reg(CFG_EPSILON + 8'd1, $urandom);
      settings_n++;
      if (ph == 0) begin
        for (int k = 0; k < 6; k++) push_cell(32'sh7fff_ffff, k == 0);
        for (int k = 0; k < 6; k++) push_cell(32'sh8000_0000, k == 0);
        // alternating extremes drive the saturation path
        for (int k = 0; k < 7; k++) push_cell(k % 2 ? 32'sh8000_0000 : 32'sh7fff_ffff, k == 0);
        // a line cut short, then the next line restarts the fill
        for (int k = 0; k < 3; k++) push_cell(sample_t'(k) <<< FRAC_BITS, k == 0);
      end
      if (ph == 2) hold_req = 1'b1;
      while (cell_q.size() < 300) push_line($urandom % 5 == 0);
      wait_idle();
    end

    $display("%0d cells in, %0d face pairs checked across %0d register settings",
             cells_n, faces_n, settings_n);
    if (err_n == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", err_n);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
